>>> design/stbs_pkg.sv
// Shared types and constants for the sorted-table binary search block.
package stbs_pkg;

    localparam int DEF_TABLE_DEPTH = 256;
    localparam int DEF_KEY_WIDTH   = 32;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int CNT_W      = 9;
    localparam int IDX_OUT_W  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMPARE_SIGNED = 8'd1;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    typedef enum logic
    {
        OP_WRITE  = 1'b0,
        OP_SEARCH = 1'b1
    } cmd_op_t;

    typedef enum logic [1:0]
    {
        ST_IDLE  = 2'b01,
        ST_PROBE = 2'b10
    } bk_state_t;

    typedef struct packed
    {
        logic        req_type;
        logic [7:0]  entry_index;
        logic [31:0] entry_value;
        logic [31:0] search_key;
    } req_t;

    typedef struct packed
    {
        logic       found;
        logic [7:0] match_index;
    } res_t;

endpackage

>>> design/stbs_front.sv
// Front end: accepts items, drops out-of-range writes, queues commands for the back end.
module stbs_front #(
    parameter int TABLE_DEPTH = stbs_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_WIDTH   = stbs_pkg::DEF_KEY_WIDTH,
    localparam int IDX_W      = $clog2(TABLE_DEPTH)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  stbs_pkg::req_t         req,
    output logic                   cmd_valid,
    output stbs_pkg::cmd_op_t      cmd_op,
    output logic [IDX_W-1:0]       cmd_addr,
    output logic [KEY_WIDTH-1:0]   cmd_key,
    input  logic                   cmd_pop
);
    import stbs_pkg::*;

    cmd_op_t              op_q_reg   [2];
    logic [IDX_W-1:0]     addr_q_reg [2];
    logic [KEY_WIDTH-1:0] key_q_reg  [2];
    logic                 wr_ptr_reg, wr_ptr_next;
    logic                 rd_ptr_reg, rd_ptr_next;
    logic [1:0]           count_reg, count_next;

    logic                 accept;
    logic                 in_range;
    logic                 enq;
    logic [31:0]          idx_wide;
    logic [63:0]          val_wide;
    cmd_op_t              new_op;
    logic [IDX_W-1:0]     new_addr;
    logic [KEY_WIDTH-1:0] new_key;

    always_comb
    begin
        accept   = push & ~full;
        idx_wide = 32'(req.entry_index);
        in_range = idx_wide < 32'(TABLE_DEPTH);
        new_addr = idx_wide[IDX_W-1:0];
        if (req.req_type == REQ_SEARCH)
        begin
            new_op   = OP_SEARCH;
            val_wide = {32'b0, req.search_key};
        end
        else
        begin
            new_op   = OP_WRITE;
            val_wide = {32'b0, req.entry_value};
        end
        new_key = val_wide[KEY_WIDTH-1:0];
        enq     = accept & ((req.req_type == REQ_SEARCH) | in_range);

        wr_ptr_next = wr_ptr_reg ^ enq;
        rd_ptr_next = rd_ptr_reg ^ cmd_pop;
        case ({enq, cmd_pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            op_q_reg[wr_ptr_reg]   <= new_op;
            addr_q_reg[wr_ptr_reg] <= new_addr;
            key_q_reg[wr_ptr_reg]  <= new_key;
        end
    end

    assign full      = count_reg == 2'd2;
    assign cmd_valid = count_reg != 2'd0;
    assign cmd_op    = op_q_reg[rd_ptr_reg];
    assign cmd_addr  = addr_q_reg[rd_ptr_reg];
    assign cmd_key   = key_q_reg[rd_ptr_reg];

endmodule

>>> design/stbs_back.sv
// Back end: key table memory and the one-probe-per-cycle search sequencer.
module stbs_back #(
    parameter int TABLE_DEPTH = stbs_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_WIDTH   = stbs_pkg::DEF_KEY_WIDTH,
    localparam int IDX_W      = $clog2(TABLE_DEPTH)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  stbs_pkg::cmd_op_t             cmd_op,
    input  logic [IDX_W-1:0]              cmd_addr,
    input  logic [KEY_WIDTH-1:0]          cmd_key,
    output logic                          cmd_pop,
    input  logic [stbs_pkg::CNT_W-1:0]    entry_count,
    input  logic                          compare_signed,
    input  logic                          rq_full,
    output logic                          rq_push,
    output stbs_pkg::res_t                rq_res
);
    import stbs_pkg::*;

    localparam int SPAN_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [KEY_WIDTH-1:0] KEY_SIGN = KEY_WIDTH'(1) << (KEY_WIDTH - 1);

    logic [KEY_WIDTH-1:0] mem [TABLE_DEPTH];
    logic [KEY_WIDTH-1:0] rd_data_reg;

    bk_state_t            state_reg, state_next;
    logic [IDX_W-1:0]     start_reg, start_next;
    logic [SPAN_W-1:0]    span_reg, span_next;
    logic [IDX_W-1:0]     probe_reg;
    logic [KEY_WIDTH-1:0] key_reg;

    logic                 mem_we;
    logic [IDX_W-1:0]     rd_addr;
    logic                 start_search;
    logic [31:0]          cnt_wide;
    logic [31:0]          cnt_sat;
    logic [SPAN_W-1:0]    count;
    logic [KEY_WIDTH-1:0] flip;
    logic                 eq;
    logic                 lt;
    logic [SPAN_W-1:0]    half;
    logic [SPAN_W-1:0]    psum;
    logic [31:0]          probe_wide;

    always_comb
    begin
        cnt_wide = 32'(entry_count);
        cnt_sat  = (cnt_wide > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : cnt_wide;
        count    = cnt_sat[SPAN_W-1:0];

        flip = compare_signed ? KEY_SIGN : '0;
        eq   = key_reg == rd_data_reg;
        lt   = (key_reg ^ flip) < (rd_data_reg ^ flip);
        half = span_reg >> 1;

        if (lt)
        begin
            span_next  = half;
            start_next = start_reg;
        end
        else
        begin
            span_next  = span_reg - half;
            start_next = probe_reg;
        end
        psum       = SPAN_W'(start_next) + (span_next >> 1);
        probe_wide = 32'(probe_reg);

        state_next   = state_reg;
        mem_we       = 1'b0;
        cmd_pop      = 1'b0;
        rq_push      = 1'b0;
        rq_res       = '0;
        start_search = 1'b0;
        rd_addr      = IDX_W'(psum);

        unique case (state_reg)
            ST_IDLE:
            begin
                rd_addr = IDX_W'(count >> 1);
                if (cmd_valid)
                begin
                    if (cmd_op == OP_WRITE)
                    begin
                        mem_we  = 1'b1;
                        cmd_pop = 1'b1;
                    end
                    else if (!rq_full)
                    begin
                        cmd_pop = 1'b1;
                        if (count == '0)
                        begin
                            rq_push = 1'b1;
                        end
                        else
                        begin
                            start_search = 1'b1;
                            state_next   = ST_PROBE;
                        end
                    end
                end
            end
            ST_PROBE:
            begin
                if (eq || (probe_reg == start_reg))
                begin
                    rq_push            = 1'b1;
                    rq_res.found       = eq;
                    rq_res.match_index = eq ? probe_wide[IDX_OUT_W-1:0] : '0;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_search)
        begin
            start_reg <= '0;
            span_reg  <= count;
            key_reg   <= cmd_key;
        end
        else if (state_reg == ST_PROBE)
        begin
            start_reg <= start_next;
            span_reg  <= span_next;
        end
        probe_reg <= rd_addr;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cmd_addr] <= cmd_key;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

>>> design/stbs_rq.sv
// Two-entry result queue between the search sequencer and the result port.
module stbs_rq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  stbs_pkg::res_t res_in,
    input  logic           pop,
    output logic           empty,
    output stbs_pkg::res_t res_out
);
    import stbs_pkg::*;

    res_t       q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       deq;

    always_comb
    begin
        deq = pop & ~empty;
        case ({push, deq})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg ^ push;
            rd_ptr_reg <= rd_ptr_reg ^ deq;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= res_in;
        end
    end

    assign full    = count_reg == 2'd2;
    assign empty   = count_reg == 2'd0;
    assign res_out = q_reg[rd_ptr_reg];

endmodule

>>> design/sorted_table_binary_search.sv
// Top level of the sorted-table binary search block.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------
//  request  | push / full          | req (req_type, entry_index, entry_value, search_key)
//  result   | pop / empty          | res (found, match_index)
//  config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A write is done by the back end in its idle state. A search starts in the idle
// state and then takes one probe per cycle, with the registered read port of the
// key table feeding the compare.
// Reset clears queues, sequencer and config (entry_count 0, compare_signed 1);
// the key table is not cleared. A full result queue holds searches in the front queue.
module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = stbs_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_WIDTH   = stbs_pkg::DEF_KEY_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  stbs_pkg::req_t                  req,
    input  logic                            pop,
    output logic                            empty,
    output stbs_pkg::res_t                  res,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [stbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [stbs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import stbs_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    logic [CNT_W-1:0]     entry_count_reg;
    logic                 compare_signed_reg;

    logic                 cmd_valid;
    cmd_op_t              cmd_op;
    logic [IDX_W-1:0]     cmd_addr;
    logic [KEY_WIDTH-1:0] cmd_key;
    logic                 cmd_pop;
    logic                 rq_full;
    logic                 rq_push;
    res_t                 rq_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg    <= '0;
            compare_signed_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_ENTRY_COUNT)
            begin
                entry_count_reg <= cfg_data[CNT_W-1:0];
            end
            else if (cfg_index == REG_COMPARE_SIGNED)
            begin
                compare_signed_reg <= cfg_data[0];
            end
        end
    end

    stbs_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_op    (cmd_op),
        .cmd_addr  (cmd_addr),
        .cmd_key   (cmd_key),
        .cmd_pop   (cmd_pop)
    );

    stbs_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_op         (cmd_op),
        .cmd_addr       (cmd_addr),
        .cmd_key        (cmd_key),
        .cmd_pop        (cmd_pop),
        .entry_count    (entry_count_reg),
        .compare_signed (compare_signed_reg),
        .rq_full        (rq_full),
        .rq_push        (rq_push),
        .rq_res         (rq_res)
    );

    stbs_rq u_rq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (rq_push),
        .full    (rq_full),
        .res_in  (rq_res),
        .pop     (pop),
        .empty   (empty),
        .res_out (res)
    );

endmodule

>>> design/stbs_check.sv
// Port-level checks for the sorted-table binary search block, bound to the top level.
module stbs_check (
    input logic           clk,
    input logic           rst_n,
    input logic           pop,
    input logic           empty,
    input stbs_pkg::res_t res,
    input logic           cfg_ready
);
    import stbs_pkg::*;

    a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty)
        else $error("waiting result item withdrawn");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> $stable(res))
        else $error("waiting result item changed");

    a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !res.found |-> res.match_index == '0)
        else $error("miss carries a nonzero index");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config channel not ready");

endmodule

bind sorted_table_binary_search stbs_check u_check (.*);
